// ===== hdl/tlphd_pkg.sv =====
`timescale 1ns / 1ps

package tlphd_pkg;

	localparam logic [7:0] IDE_FMT_TYPE = 8'h92;
	localparam logic [4:0] TYPE_MRD32 = 5'h00;
	localparam logic [4:0] TYPE_MRD_LK = 5'h01;
	localparam logic [4:0] TYPE_DEFERRED = 5'h1B;
	localparam logic [2:0] FMT_3DW_NODATA = 3'd0;
	localparam logic [2:0] FMT_4DW_NODATA = 3'd1;
	localparam logic [2:0] FMT_3DW_DATA = 3'd2;
	localparam logic [2:0] FMT_4DW_DATA = 3'd3;
	localparam logic [4:0] NFM_ENABLE_OFFSET = 5'd7;
	localparam logic [4:0] A1_ENABLE_GAP = 5'd3;
	localparam logic [3:0] ADDRESS_OFFSET = 4'd8;
	localparam logic [2:0] DW_NONE = 3'd0;
	localparam logic [2:0] DW_ONE = 3'd1;
	localparam logic [2:0] DW_THREE = 3'd3;
	localparam logic [2:0] DW_FOUR = 3'd4;
	localparam logic [2:0] DW_FIVE = 3'd5;
	localparam logic [2:0] DW_SIX = 3'd6;
	localparam logic [2:0] DW_SEVEN = 3'd7;

	typedef struct packed {
		logic       flit_mode_off;
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
	} in_word_t;

	typedef struct packed {
		logic        is_protected;
		logic [4:0]  header_bytes;
		logic [3:0]  address_offset;
		logic [4:0]  enable_offset;
		logic        enable_present;
		logic [11:0] payload_bytes;
	} out_word_t;

	typedef struct packed {
		logic [2:0] dw;
		logic       a1_type;
	} flit_info_t;

	function automatic logic in_rng(input logic [7:0] t, input logic [7:0] lo,
		input logic [7:0] hi);
		return (t >= lo) && (t <= hi);
	endfunction

	function automatic logic [2:0] flit_dw(input logic [7:0] t);
		logic [2:0] dw;
		dw = DW_NONE;
		if (t == 8'd0 || in_rng(t, 8'd128, 8'd143)) begin
			dw = DW_ONE;
		end else if (in_rng(t, 8'd1, 8'd5) || in_rng(t, 8'd8, 8'd15)
			|| in_rng(t, 8'd28, 8'd29) || t == 8'd64 || t == 8'd66
			|| in_rng(t, 8'd68, 8'd78) || in_rng(t, 8'd88, 8'd89)
			|| t == 8'd91) begin
			dw = DW_THREE;
		end else if (in_rng(t, 8'd6, 8'd7) || in_rng(t, 8'd32, 8'd45)
			|| in_rng(t, 8'd48, 8'd61) || t == 8'd79 || t == 8'd90
			|| in_rng(t, 8'd92, 8'd93) || in_rng(t, 8'd96, 8'd127)
			|| in_rng(t, 8'd144, 8'd147) || in_rng(t, 8'd224, 8'd225)
			|| in_rng(t, 8'd228, 8'd229) || in_rng(t, 8'd240, 8'd241)) begin
			dw = DW_FOUR;
		end else if (in_rng(t, 8'd16, 8'd21) || in_rng(t, 8'd46, 8'd47)
			|| in_rng(t, 8'd62, 8'd63) || in_rng(t, 8'd94, 8'd95)
			|| in_rng(t, 8'd148, 8'd151) || in_rng(t, 8'd160, 8'd167)
			|| in_rng(t, 8'd172, 8'd173) || in_rng(t, 8'd176, 8'd191)
			|| in_rng(t, 8'd202, 8'd203) || in_rng(t, 8'd242, 8'd243)) begin
			dw = DW_FIVE;
		end else if (in_rng(t, 8'd30, 8'd31) || t == 8'd65 || t == 8'd67
			|| in_rng(t, 8'd80, 8'd85) || in_rng(t, 8'd152, 8'd155)
			|| in_rng(t, 8'd168, 8'd169) || in_rng(t, 8'd174, 8'd175)
			|| in_rng(t, 8'd192, 8'd199) || in_rng(t, 8'd204, 8'd205)
			|| in_rng(t, 8'd208, 8'd223) || in_rng(t, 8'd226, 8'd227)
			|| in_rng(t, 8'd230, 8'd231) || in_rng(t, 8'd244, 8'd245)) begin
			dw = DW_SIX;
		end else if (in_rng(t, 8'd22, 8'd27) || in_rng(t, 8'd86, 8'd87)
			|| in_rng(t, 8'd156, 8'd159) || in_rng(t, 8'd170, 8'd171)
			|| in_rng(t, 8'd200, 8'd201) || in_rng(t, 8'd206, 8'd207)
			|| in_rng(t, 8'd232, 8'd239) || in_rng(t, 8'd246, 8'd255)) begin
			dw = DW_SEVEN;
		end
		return dw;
	endfunction

	function automatic logic flit_a1(input logic [7:0] t);
		return t == 8'd1 || t == 8'd3 || t == 8'd32 || t == 8'd33
			|| t == 8'd64 || t == 8'd91 || t == 8'd96 || t == 8'd123;
	endfunction

endpackage

// ===== hdl/tlphd_type_lookup.sv =====
`timescale 1ns / 1ps

module tlphd_type_lookup (
	input  logic [7:0]              flit_type,
	output tlphd_pkg::flit_info_t   info
);

	assign info.dw = tlphd_pkg::flit_dw(flit_type);
	assign info.a1_type = tlphd_pkg::flit_a1(flit_type);

endmodule

// ===== hdl/pcie_tlp_header_field_decoder_top.sv =====
`timescale 1ns / 1ps
// An accepted header word passes through stages s1, s2 and s3 to its result word.
// Throughput: one word per cycle unless res_stall holds a full last stage; the
// lookup, the header size decode and the enable offset add each hold one pipeline stage.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
module pcie_tlp_header_field_decoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hdr_valid,
	output logic                 hdr_stall,
	input  tlphd_pkg::in_word_t  hdr,
	output logic                 res_valid,
	input  logic                 res_stall,
	output tlphd_pkg::out_word_t res
);

	tlphd_pkg::flit_info_t flit_info;
	logic       advance;
	logic [2:0] dw_c;
	logic       en_cond_c;

	logic        valid_s1, valid_s2, valid_s3;
	logic        nfm_s1, nfm_s2;
	logic [2:0]  dw_s1;
	logic        en_cond_s1, en_cond_s2;
	logic        prot_s1, prot_s2;
	logic [11:0] len_s1, len_s2;
	logic [4:0]  hdr_bytes_s2;
	logic [3:0]  addr_s2;
	tlphd_pkg::out_word_t res_s3;

	tlphd_type_lookup u_lookup (
		.flit_type (hdr.byte_zero),
		.info      (flit_info)
	);

	assign advance = !valid_s3 || !res_stall;
	assign hdr_stall = !advance;

	always_comb begin
		if (hdr.flit_mode_off) begin
			case (hdr.byte_zero[7:5])
				tlphd_pkg::FMT_3DW_NODATA, tlphd_pkg::FMT_3DW_DATA: dw_c = tlphd_pkg::DW_THREE;
				tlphd_pkg::FMT_4DW_NODATA, tlphd_pkg::FMT_4DW_DATA: dw_c = tlphd_pkg::DW_FOUR;
				default: dw_c = tlphd_pkg::DW_NONE;
			endcase
			en_cond_c = (hdr.byte_zero[4:0] == tlphd_pkg::TYPE_MRD32
				|| hdr.byte_zero[4:0] == tlphd_pkg::TYPE_MRD_LK
				|| hdr.byte_zero[4:0] == tlphd_pkg::TYPE_DEFERRED)
				&& !hdr.byte_one[0];
		end else begin
			dw_c = flit_info.dw;
			en_cond_c = flit_info.a1_type && hdr.byte_one[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= hdr_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nfm_s1 <= hdr.flit_mode_off;
			dw_s1 <= dw_c;
			en_cond_s1 <= en_cond_c;
			prot_s1 <= hdr.flit_mode_off ? (hdr.byte_zero == tlphd_pkg::IDE_FMT_TYPE)
				: hdr.byte_one[2];
			len_s1 <= {hdr.byte_two[1:0], hdr.byte_three, 2'b00};

			nfm_s2 <= nfm_s1;
			en_cond_s2 <= en_cond_s1;
			prot_s2 <= prot_s1;
			len_s2 <= len_s1;
			hdr_bytes_s2 <= {dw_s1, 2'b00};
			addr_s2 <= (dw_s1 >= tlphd_pkg::DW_THREE) ? tlphd_pkg::ADDRESS_OFFSET : 4'd0;

			res_s3.is_protected <= prot_s2;
			res_s3.header_bytes <= hdr_bytes_s2;
			res_s3.address_offset <= addr_s2;
			res_s3.enable_offset <= !en_cond_s2 ? 5'd0
				: (nfm_s2 ? tlphd_pkg::NFM_ENABLE_OFFSET
				: hdr_bytes_s2 + tlphd_pkg::A1_ENABLE_GAP);
			res_s3.enable_present <= en_cond_s2;
			res_s3.payload_bytes <= len_s2;
		end
	end

	assign res_valid = valid_s3;
	assign res = res_s3;

endmodule

// ===== hdl/tlphd_checker.sv =====
`timescale 1ns / 1ps

module tlphd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 hdr_stall,
	input logic                 res_valid,
	input logic                 res_stall,
	input tlphd_pkg::out_word_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> hdr_stall)
		else $error("header word taken while full pipe is stalled");

	a_enable_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.enable_present == (res.enable_offset != 5'd0))
		else $error("enable flag disagrees with enable offset");

	a_addr_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.address_offset == 4'd0 || res.address_offset == 4'd8)
			&& ((res.address_offset == 4'd8) == (res.header_bytes >= 5'd12)))
		else $error("address offset disagrees with header size");

endmodule

bind pcie_tlp_header_field_decoder_top tlphd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hdr_stall (hdr_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
